@@ src/btmx_pkg.sv @@
// btmx_pkg: shared types and codes for the binary trie max-xor block.
// No dependencies; used by binary_trie_max_xor_top.
`default_nettype none

package btmx_pkg;

   // Command codes on req_command
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

`default_nettype wire

@@ src/binary_trie_max_xor_top.sv @@
// binary_trie_max_xor_top: binary trie holding keys, answers max-xor queries.
// Depends on btmx_pkg (state type, command codes).
//
// Usage:
//   Input channel: drive req_command / req_key and raise start; the transaction
//   is taken at a rising edge with start high and busy low. req_command
//   CMD_INSERT adds the key, CMD_QUERY returns the largest XOR of the key with
//   any stored key (0 when the trie is empty).
//   Result channel: rsp_valid pulses for exactly one cycle with rsp_max_xor
//   and rsp_rejected. The receiver cannot stall, so it must sample then.
//   Walk: an accepted transaction walks one trie level per cycle through
//   the node memory (one synchronous read per level) while busy is high, so
//   no new transaction is taken until it ends; the result is registered
//   onto the result channel when the walk ends. A query that hits an empty
//   root finishes after its first level. An insert refused for lack of free
//   nodes (fewer than KEY_BITS left) is answered the next cycle, busy stays low.
//   Reset: synchronous, active high. The node counter returns to the root; the
//   node memory is not swept. Entries beyond the allocation counter are never
//   read, and a freshly allocated node is treated as empty, so no clearing
//   pass is needed and the block is ready the cycle after reset.
`default_nettype none

module binary_trie_max_xor_top #(
   parameter int KEY_BITS   = 31,
   parameter int NODE_COUNT = 65536
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_command,
   input  wire logic [KEY_BITS-1:0] req_key,
   output logic                     rsp_valid,
   output logic [KEY_BITS-1:0]      rsp_max_xor,
   output logic                     rsp_rejected
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int CNT_W  = NODE_W + 1;
   localparam int ENT_W  = 2 * NODE_W;

   localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);
   localparam logic [LVL_W-1:0]  LVL_LAST = LVL_W'(KEY_BITS - 1);
   localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(NODE_COUNT - 1);
   localparam logic [CNT_W-1:0]  NEED     = CNT_W'(KEY_BITS);

   // Node memory: each entry holds {child for bit 1, child for bit 0}
   logic [ENT_W-1:0] node_mem [NODE_COUNT];
   logic [ENT_W-1:0] rdata_ff;
   logic [NODE_W-1:0] rd_addr;
   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [ENT_W-1:0]  wr_data;

   btmx_pkg::state_type state_ff, state_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   nf_ff, nf_in;       // highest node allocated
   logic                fresh_ff, fresh_in; // current node not yet written
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic                cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic                rsp_rej_ff, rsp_rej_in;

   logic [ENT_W-1:0]  eff;
   logic [NODE_W-1:0] link0, link1;
   logic [NODE_W-1:0] next_node;
   logic              key_bit;
   logic              no_room;
   logic              done;

   // Fresh node reads as empty; its memory entry may hold stale data
   assign eff   = fresh_ff ? '0 : rdata_ff;
   assign link0 = eff[NODE_W-1:0];
   assign link1 = eff[ENT_W-1:NODE_W];
   assign key_bit = key_ff[level_ff];

   // Refuse insert when fewer than KEY_BITS free nodes remain
   assign no_room = (LAST_IDX - {1'b0, nf_ff}) < NEED;

   always_ff @(posedge clock) begin
      rdata_ff <= node_mem[rd_addr];
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btmx_pkg::ST_IDLE;
         nf_ff        <= ROOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      cur_ff     <= cur_in;
      fresh_ff   <= fresh_in;
      acc_ff     <= acc_in;
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      rsp_max_ff <= rsp_max_in;
      rsp_rej_ff <= rsp_rej_in;
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      nf_in        = nf_ff;
      fresh_in     = fresh_ff;
      acc_in       = acc_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_max_in   = rsp_max_ff;
      rsp_rej_in   = rsp_rej_ff;
      rd_addr      = ROOT;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = eff;
      next_node    = '0;
      done         = 1'b0;
      unique case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (start) begin
               if (req_command == btmx_pkg::CMD_INSERT && no_room) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = '0;
                  rsp_rej_in   = 1'b1;
               end else begin
                  cmd_in   = req_command;
                  key_in   = req_key;
                  level_in = LVL_LAST;
                  cur_in   = ROOT;
                  fresh_in = (nf_ff == ROOT);  // empty trie: root never written
                  acc_in   = '0;
                  state_in = btmx_pkg::ST_WALK;
               end
            end
         end
         btmx_pkg::ST_WALK: begin
            if (cmd_ff == btmx_pkg::CMD_INSERT) begin
               if ((key_bit ? link1 : link0) == '0) begin
                  // allocate a node; all deeper nodes on this path are fresh
                  next_node = nf_ff + NODE_W'(1);
                  nf_in     = next_node;
                  wr_en     = 1'b1;
                  wr_data   = key_bit ? {next_node, link0} : {link1, next_node};
                  fresh_in  = 1'b1;
               end else begin
                  next_node = key_bit ? link1 : link0;
               end
            end else begin
               // greedy: prefer the child on the opposite bit
               if ((key_bit ? link0 : link1) != '0) begin
                  next_node        = key_bit ? link0 : link1;
                  acc_in[level_ff] = 1'b1;
               end else if ((key_bit ? link1 : link0) != '0) begin
                  next_node = key_bit ? link1 : link0;
               end else begin
                  done = 1'b1;  // dead end, only at an empty root
               end
            end
            cur_in  = next_node;
            rd_addr = next_node;
            if (level_ff == '0) begin
               done = 1'b1;
            end else begin
               level_in = level_ff - LVL_W'(1);
            end
            if (done) begin
               rsp_valid_in = 1'b1;
               rsp_rej_in   = 1'b0;
               rsp_max_in   = (cmd_ff == btmx_pkg::CMD_QUERY) ? acc_in : '0;
               state_in     = btmx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btmx_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != btmx_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_xor  = rsp_max_ff;
   assign rsp_rejected = rsp_rej_ff;

   // Accepted transaction either starts a walk or is answered at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither walking nor answered");

   // A refused insert never carries an xor value
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_max_xor == '0))
      else $error("rejected result with nonzero max_xor");

   // Allocation counter only grows and stays inside the node memory
   a_alloc_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (nf_ff >= $past(nf_ff)))
      else $error("node allocation counter moved backward");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, nf_ff} <= LAST_IDX))
      else $error("node allocation counter past end of node memory");

endmodule

`default_nettype wire
